[rtl/arpc_pkg.sv]
// ----------------------------------------------------------------------------
// arpc_pkg
// Types and constants shared by the address cache core and its testbench.
// ----------------------------------------------------------------------------
package arpc_pkg;

   localparam int DEFAULT_ENTRIES = 16;

   localparam logic [7:0]  OCTET_BCAST = 8'hFF;
   localparam logic [31:0] BCAST_IP    = 32'hFFFF_FFFF;
   localparam logic [47:0] MAC_ONES    = 48'hFFFF_FFFF_FFFF;

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [1:0] STATUS_INSERTED  = 2'd0;
   localparam logic [1:0] STATUS_REFRESHED = 2'd1;
   localparam logic [1:0] STATUS_IGNORED   = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;
   localparam logic [1:0] STATUS_LOOKUP    = 2'd0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic        command;
      logic [31:0] ip_addr;
      logic [47:0] mac_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        hit;
      logic [47:0] mac_out;
   } rsp_type;

   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
   } entry_type;

endpackage

[rtl/arpc_ram.sv]
// ----------------------------------------------------------------------------
// arpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module arpc_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/arp_address_cache_core.sv]
// ----------------------------------------------------------------------------
// arp_address_cache_core
// Bounded IPv4 to MAC address table with update and lookup commands.
//
// A command beat is taken when start is high and busy is low. An update
// stores or refreshes the MAC for an address; a lookup reports hit and MAC.
// Updates for address zero or an x.x.x.255 address are ignored; a lookup of
// 255.255.255.255 hits with an all-ones MAC. Each command gives exactly one
// result beat: rsp_valid is high for one cycle with rsp_data.
// Ignored updates and broadcast lookups answer in the cycle after the start
// beat. Other commands scan the filled entries through one RAM read port and
// one address comparator, one entry per cycle; a hit ends the scan at the
// first matching entry, a miss ends it after the last filled entry. busy stays
// high until the result beat has been shown; a new start is taken the cycle after.
// Entries fill from index zero and are never removed, so a fill count marks
// which entries are live. Reset empties the table at once, with no sweep.
// The receiver cannot stall: each result beat is taken in the cycle shown.
// ----------------------------------------------------------------------------
module arp_address_cache_core #(
   parameter int ENTRIES = arpc_pkg::DEFAULT_ENTRIES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  arpc_pkg::req_type req_data,
   output logic              rsp_valid,
   output arpc_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int EW = $bits(arpc_pkg::entry_type);

   arpc_pkg::state_type state_ff, state_in;
   arpc_pkg::req_type   req_ff, req_in;
   arpc_pkg::rsp_type   rsp_ff, rsp_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       scan_ff, scan_in;
   logic                pend_ff, pend_in;
   logic [AW-1:0]       pend_idx_ff, pend_idx_in;

   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   arpc_pkg::entry_type ram_wr_entry;
   logic [AW-1:0]       ram_rd_addr;
   logic [EW-1:0]       ram_rd_raw;
   arpc_pkg::entry_type rd_entry;

   logic quick;
   logic found;
   logic exhausted;
   logic is_bcast_lookup;
   logic is_ignored_update;

   arpc_ram #(
      .WIDTH (EW),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (EW'(ram_wr_entry)),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   assign rd_entry = arpc_pkg::entry_type'(ram_rd_raw);

   assign is_bcast_lookup   = (req_data.command == arpc_pkg::CMD_LOOKUP)
                              && (req_data.ip_addr == arpc_pkg::BCAST_IP);
   assign is_ignored_update = (req_data.command == arpc_pkg::CMD_UPDATE)
                              && ((req_data.ip_addr == 32'd0)
                                  || (req_data.ip_addr[7:0] == arpc_pkg::OCTET_BCAST));
   assign quick     = is_bcast_lookup || is_ignored_update;
   assign found     = pend_ff && (rd_entry.ip == req_ff.ip_addr);
   assign exhausted = !pend_ff && (scan_ff == count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         arpc_pkg::ST_IDLE: begin
            if (start) begin
               state_in = quick ? arpc_pkg::ST_REPLY : arpc_pkg::ST_SCAN;
            end
         end
         arpc_pkg::ST_SCAN: begin
            if (found || exhausted) begin
               state_in = arpc_pkg::ST_REPLY;
            end
         end
         arpc_pkg::ST_REPLY: begin
            state_in = arpc_pkg::ST_IDLE;
         end
         default: begin
            state_in = arpc_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = pend_idx_ff;
      ram_wr_entry = '{ip: req_ff.ip_addr, mac: req_ff.mac_in};
      ram_rd_addr  = scan_ff[AW-1:0];
      case (state_ff)
         arpc_pkg::ST_IDLE: begin
            if (start) begin
               req_in         = req_data;
               scan_in        = '0;
               rsp_in.status  = (req_data.command == arpc_pkg::CMD_UPDATE)
                                ? arpc_pkg::STATUS_IGNORED : arpc_pkg::STATUS_LOOKUP;
               rsp_in.hit     = is_bcast_lookup;
               rsp_in.mac_out = is_bcast_lookup ? arpc_pkg::MAC_ONES : 48'd0;
            end
         end
         arpc_pkg::ST_SCAN: begin
            if (scan_ff != count_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[AW-1:0];
               scan_in     = scan_ff + 1'b1;
            end
            if (found) begin
               if (req_ff.command == arpc_pkg::CMD_LOOKUP) begin
                  rsp_in = '{status: arpc_pkg::STATUS_LOOKUP, hit: 1'b1,
                             mac_out: rd_entry.mac};
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = pend_idx_ff;
                  rsp_in = '{status: arpc_pkg::STATUS_REFRESHED, hit: 1'b0,
                             mac_out: 48'd0};
               end
            end else if (exhausted) begin
               if (req_ff.command == arpc_pkg::CMD_LOOKUP) begin
                  rsp_in = '{status: arpc_pkg::STATUS_LOOKUP, hit: 1'b0,
                             mac_out: 48'd0};
               end else if (count_ff != CW'(ENTRIES)) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = count_ff[AW-1:0];
                  count_in    = count_ff + 1'b1;
                  rsp_in = '{status: arpc_pkg::STATUS_INSERTED, hit: 1'b0,
                             mac_out: 48'd0};
               end else begin
                  rsp_in = '{status: arpc_pkg::STATUS_FULL, hit: 1'b0,
                             mac_out: 48'd0};
               end
            end
         end
         arpc_pkg::ST_REPLY: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= arpc_pkg::ST_IDLE;
         count_ff <= '0;
         scan_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         scan_ff  <= scan_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      pend_idx_ff <= pend_idx_in;
   end

   assign busy      = (state_ff != arpc_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == arpc_pkg::ST_REPLY);
   assign rsp_data  = rsp_ff;

   a_reply_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("result beat not followed by idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ENTRIES))
      else $error("fill count beyond table size");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command beat did not raise busy");

   a_hit_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hit) |-> (rsp_data.status == arpc_pkg::STATUS_LOOKUP))
      else $error("hit with nonzero status");

   a_miss_mac: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |-> (rsp_data.mac_out == 48'd0))
      else $error("mac on a miss");

endmodule

[dv/tb_arp_address_cache_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_arp_address_cache_core
// Self-checking bench for the ARP address cache core. Command beats are sent
// through start/busy and a local copy of the table works out each reply.
// Every rsp_valid beat is compared field by field with the oldest pending
// reply. Directed cases cover ignored updates, broadcast lookups, insert,
// refresh and a full table; random traffic over a small host set then
// drives refreshes, hits, near misses and noise, with and without idle gaps.
// ----------------------------------------------------------------------------
module tb_arp_address_cache_core;

   localparam int TABLE_DEPTH = arpc_pkg::DEFAULT_ENTRIES;
   localparam int HOST_COUNT  = 24;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   arpc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   arpc_pkg::rsp_type rsp_data;

   logic [31:0]       cache_ip [TABLE_DEPTH];
   logic [47:0]       cache_mac [TABLE_DEPTH];
   int                fill_count = 0;
   logic [31:0]       known_hosts [HOST_COUNT];
   arpc_pkg::rsp_type pending_rsp [$];
   int                fail_count = 0;
   bit                idle_enabled = 1'b1;

   arp_address_cache_core uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // expected reply for one accepted beat; entries fill from index zero
   function automatic arpc_pkg::rsp_type resolve_command(arpc_pkg::req_type beat);
      arpc_pkg::rsp_type reply;
      int                slot;
      reply = '0;
      slot = -1;
      for (int i = 0; i < fill_count; i++) begin
         if (slot < 0 && cache_ip[i] == beat.ip_addr) begin
            slot = i;
         end
      end
      if (beat.command == arpc_pkg::CMD_UPDATE) begin
         if (beat.ip_addr == '0 || beat.ip_addr[7:0] == arpc_pkg::OCTET_BCAST) begin
            reply.status = arpc_pkg::STATUS_IGNORED;
         end else if (slot >= 0) begin
            cache_mac[slot] = beat.mac_in;
            reply.status = arpc_pkg::STATUS_REFRESHED;
         end else if (fill_count < TABLE_DEPTH) begin
            cache_ip[fill_count] = beat.ip_addr;
            cache_mac[fill_count] = beat.mac_in;
            fill_count++;
            reply.status = arpc_pkg::STATUS_INSERTED;
         end else begin
            reply.status = arpc_pkg::STATUS_FULL;
         end
      end else begin
         reply.status = arpc_pkg::STATUS_LOOKUP;
         if (beat.ip_addr == arpc_pkg::BCAST_IP) begin
            reply.hit = 1'b1;
            reply.mac_out = arpc_pkg::MAC_ONES;
         end else if (slot >= 0) begin
            reply.hit = 1'b1;
            reply.mac_out = cache_mac[slot];
         end
      end
      return reply;
   endfunction

   function automatic logic [47:0] rand_mac();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: return '0;
         1: return arpc_pkg::MAC_ONES;
         default: return bits[47:0];
      endcase
   endfunction

   task automatic send_command(input logic command, input logic [31:0] ip,
                               input logic [47:0] mac);
      arpc_pkg::req_type beat;
      beat = '{command: command, ip_addr: ip, mac_in: mac};
      @(negedge clock);
      start <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp.push_back(resolve_command(beat));
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(1, 17) - 1) @(negedge clock);
      end
   endtask

   // reply checker
   always @(posedge clock) begin
      arpc_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result beat: %h", rsp_data);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status mismatch: expected %0d, got %0d", want.status,
                      rsp_data.status);
               fail_count++;
            end
            if (rsp_data.hit !== want.hit) begin
               $error("hit mismatch: expected %0d, got %0d", want.hit, rsp_data.hit);
               fail_count++;
            end
            if (rsp_data.mac_out !== want.mac_out) begin
               $error("mac_out mismatch: expected %h, got %h", want.mac_out,
                      rsp_data.mac_out);
               fail_count++;
            end
         end
      end
   end

   task automatic test_empty_table();
      send_command(arpc_pkg::CMD_LOOKUP, 32'h0A00_0001, '0);
      send_command(arpc_pkg::CMD_LOOKUP, arpc_pkg::BCAST_IP, '0);
      send_command(arpc_pkg::CMD_UPDATE, 32'h0000_0000, 48'h0011_2233_4455);
      send_command(arpc_pkg::CMD_UPDATE, 32'hC0A8_01FF, 48'h0011_2233_4455);
      send_command(arpc_pkg::CMD_UPDATE, arpc_pkg::BCAST_IP, arpc_pkg::MAC_ONES);
      send_command(arpc_pkg::CMD_LOOKUP, 32'h0000_0000, arpc_pkg::MAC_ONES);
      send_command(arpc_pkg::CMD_LOOKUP, 32'h0A00_00FF, '0);
   endtask

   task automatic test_insert_refresh();
      send_command(arpc_pkg::CMD_UPDATE, 32'h0000_0001, '0);
      send_command(arpc_pkg::CMD_UPDATE, 32'hFFFF_FFFE, arpc_pkg::MAC_ONES);
      send_command(arpc_pkg::CMD_LOOKUP, 32'h0000_0001, arpc_pkg::MAC_ONES);
      send_command(arpc_pkg::CMD_LOOKUP, 32'hFFFF_FFFE, '0);
      send_command(arpc_pkg::CMD_UPDATE, 32'h0000_0001, 48'hA5A5_5A5A_C3C3);
      send_command(arpc_pkg::CMD_LOOKUP, 32'h0000_0001, '0);
   endtask

   task automatic test_random_traffic(input int beats);
      int          pick;
      logic [31:0] ip;
      for (int n = 0; n < beats; n++) begin
         pick = $urandom_range(0, 99);
         ip = known_hosts[$urandom_range(0, HOST_COUNT - 1)];
         if (pick < 45) begin
            send_command(arpc_pkg::CMD_UPDATE, ip, rand_mac());
         end else if (pick < 75) begin
            send_command(arpc_pkg::CMD_LOOKUP, ip, rand_mac());
         end else if (pick < 82) begin
            send_command(arpc_pkg::CMD_LOOKUP, ip ^ (32'd1 << $urandom_range(0, 31)),
                         rand_mac());
         end else if (pick < 87) begin
            send_command(arpc_pkg::CMD_LOOKUP, arpc_pkg::BCAST_IP, rand_mac());
         end else if (pick < 93) begin
            ip = $urandom;
            if ($urandom_range(0, 1)) begin
               ip = '0;
            end else begin
               ip[7:0] = arpc_pkg::OCTET_BCAST;
            end
            send_command(arpc_pkg::CMD_UPDATE, ip, rand_mac());
         end else begin
            send_command($urandom_range(0, 1) ? arpc_pkg::CMD_LOOKUP : arpc_pkg::CMD_UPDATE,
                         $urandom, rand_mac());
         end
      end
   endtask

   task automatic test_full_table();
      logic [31:0] ip;
      while (fill_count < TABLE_DEPTH) begin
         ip = $urandom;
         ip[7:0] = 8'($urandom_range(1, 254));
         send_command(arpc_pkg::CMD_UPDATE, ip, rand_mac());
      end
      ip = $urandom;
      ip[7:0] = 8'($urandom_range(1, 254));
      send_command(arpc_pkg::CMD_UPDATE, ip, rand_mac());
      send_command(arpc_pkg::CMD_LOOKUP, ip, '0);
      send_command(arpc_pkg::CMD_UPDATE, cache_ip[TABLE_DEPTH - 1], rand_mac());
      send_command(arpc_pkg::CMD_LOOKUP, cache_ip[TABLE_DEPTH - 1], '0);
      send_command(arpc_pkg::CMD_UPDATE, 32'h0000_0000, rand_mac());
   endtask

   initial begin
      for (int i = 0; i < HOST_COUNT; i++) begin
         known_hosts[i] = $urandom;
         known_hosts[i][15:8] = 8'(i);
         known_hosts[i][7:0] = 8'($urandom_range(1, 254));
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_insert_refresh();
      test_random_traffic(300);
      test_full_table();
      idle_enabled = 1'b0;
      test_random_traffic(300);
      @(negedge clock);
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

[sim.f]
rtl/arpc_pkg.sv
rtl/arpc_ram.sv
rtl/arp_address_cache_core.sv
dv/tb_arp_address_cache_core.sv
